// ----- rtl/best_fit_heap_allocator_top_assert.svh -----
// Assertion macros used by the allocator control logic (bfha_ctrl).
`ifndef BEST_FIT_HEAP_ALLOCATOR_TOP_ASSERT_SVH
`define BEST_FIT_HEAP_ALLOCATOR_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define BFHA_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bfha assertion failed");
`define BFHA_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bfha assertion failed");
`else
`define BFHA_ASSERT_IMP(label, ante, cons)
`define BFHA_ASSERT_NXT(label, ante, cons)
`endif
`endif

// ----- rtl/bfha_pkg.sv -----
package bfha_pkg;
    localparam int HEAP_BYTES   = 4096;
    localparam int HEADER_BYTES = 16;
    localparam int POS_W        = $clog2(HEAP_BYTES) + 1;
    localparam int DEPTH        = HEAP_BYTES / 4;
    localparam int ADDR_W       = $clog2(DEPTH);
    localparam int SIZE_W       = POS_W;
    localparam int ENT_W        = SIZE_W + 1;
    localparam int REQ_W        = 16;
    localparam int NEED_W       = REQ_W + 1;
    localparam int AREA_W       = 12;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOFIT   = 2'd1;
    localparam logic [1:0] ST_BADFREE = 2'd2;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_A_WALK,
        S_A_END,
        S_A_MARK,
        S_F_WALK,
        S_F_NEXT,
        S_F_MERGE,
        S_DONE
    } state_t;

    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [ENT_W-1:0]  wr_data;
    } mem_req_t;

    // entry = {used, size}
    localparam logic [ENT_W-1:0] RESET_ENTRY = {1'b0, SIZE_W'(HEAP_BYTES)};
endpackage

// ----- rtl/bfha_ram.sv -----
module bfha_ram #(
    parameter int WIDTH = 14,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

// ----- rtl/bfha_ctrl.sv -----
`include "best_fit_heap_allocator_top_assert.svh"
module bfha_ctrl (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic                     opcode,
    input  logic [bfha_pkg::REQ_W-1:0]  request_bytes,
    input  logic [bfha_pkg::AREA_W-1:0] area_offset,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [1:0]               status,
    output logic [bfha_pkg::AREA_W-1:0] granted_offset,
    output bfha_pkg::mem_req_t       mem_req,
    input  logic [bfha_pkg::ENT_W-1:0]  mem_rdata
);
    import bfha_pkg::*;

    state_t              state_reg, state_next;
    logic [NEED_W-1:0]   need_reg, need_next;
    logic [POS_W-1:0]    target_reg, target_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [POS_W-1:0]    prev_reg, prev_next;
    logic                prev_used_reg, prev_used_next;
    logic [SIZE_W-1:0]   prev_size_reg, prev_size_next;
    logic                has_prev_reg, has_prev_next;
    logic                found_reg, found_next;
    logic [POS_W-1:0]    best_reg, best_next;
    logic [SIZE_W-1:0]   best_size_reg, best_size_next;
    logic [SIZE_W-1:0]   cur_size_reg, cur_size_next;
    logic [1:0]          res_status_reg, res_status_next;
    logic [AREA_W-1:0]   res_off_reg, res_off_next;
    logic                out_valid_reg;
    logic [1:0]          status_reg;
    logic [AREA_W-1:0]   granted_reg;
    logic                load_out;

    logic                ent_used;
    logic [SIZE_W-1:0]   ent_size;
    logic [POS_W:0]      npos;
    logic                fits;
    logic [NEED_W-1:0]   need_in;

    assign ent_used = mem_rdata[ENT_W-1];
    assign ent_size = mem_rdata[SIZE_W-1:0];
    assign npos     = {1'b0, pos_reg} + {1'b0, ent_size};
    assign fits     = !ent_used && (NEED_W'(ent_size) >= need_reg)
                      && (!found_reg || ent_size < best_size_reg);
    assign need_in  = ((NEED_W'(request_bytes) + NEED_W'(3)) & ~NEED_W'(3))
                      + NEED_W'(HEADER_BYTES);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        need_reg       <= need_next;
        target_reg     <= target_next;
        pos_reg        <= pos_next;
        prev_reg       <= prev_next;
        prev_used_reg  <= prev_used_next;
        prev_size_reg  <= prev_size_next;
        has_prev_reg   <= has_prev_next;
        found_reg      <= found_next;
        best_reg       <= best_next;
        best_size_reg  <= best_size_next;
        cur_size_reg   <= cur_size_next;
        res_status_reg <= res_status_next;
        res_off_reg    <= res_off_next;
        if (load_out)
        begin
            status_reg  <= res_status_reg;
            granted_reg <= res_off_reg;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        need_next       = need_reg;
        target_next     = target_reg;
        pos_next        = pos_reg;
        prev_next       = prev_reg;
        prev_used_next  = prev_used_reg;
        prev_size_next  = prev_size_reg;
        has_prev_next   = has_prev_reg;
        found_next      = found_reg;
        best_next       = best_reg;
        best_size_next  = best_size_reg;
        cur_size_next   = cur_size_reg;
        res_status_next = res_status_reg;
        res_off_next    = res_off_reg;
        mem_req         = '0;
        load_out        = 1'b0;
        in_stall        = 1'b1;

        unique case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    pos_next      = '0;
                    found_next    = 1'b0;
                    has_prev_next = 1'b0;
                    need_next     = need_in;
                    res_off_next  = '0;
                    if (opcode == OP_ALLOC)
                    begin
                        mem_req.rd_en = 1'b1;
                        state_next    = S_A_WALK;
                    end
                    else if (AREA_W'(area_offset) < AREA_W'(HEADER_BYTES))
                    begin
                        res_status_next = ST_BADFREE;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        target_next   = POS_W'(area_offset) - POS_W'(HEADER_BYTES);
                        mem_req.rd_en = 1'b1;
                        state_next    = S_F_WALK;
                    end
                end
            end
            S_A_WALK:
            begin
                if (fits)
                begin
                    best_next      = pos_reg;
                    best_size_next = ent_size;
                    found_next     = 1'b1;
                end
                if (fits && NEED_W'(ent_size) == need_reg)
                begin
                    state_next = S_A_END;
                end
                else if (npos >= (POS_W+1)'(HEAP_BYTES))
                begin
                    state_next = S_A_END;
                end
                else
                begin
                    pos_next        = npos[POS_W-1:0];
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = npos[ADDR_W+1:2];
                end
            end
            S_A_END:
            begin
                if (!found_reg)
                begin
                    res_status_next = ST_NOFIT;
                    state_next      = S_DONE;
                end
                else
                begin
                    if (NEED_W'(best_size_reg) >= need_reg + NEED_W'(2 * HEADER_BYTES))
                    begin
                        mem_req.wr_en   = 1'b1;
                        mem_req.wr_addr = ADDR_W'((best_reg + need_reg[POS_W-1:0]) >> 2);
                        mem_req.wr_data = {1'b0, best_size_reg - need_reg[SIZE_W-1:0]};
                        best_size_next  = need_reg[SIZE_W-1:0];
                    end
                    state_next = S_A_MARK;
                end
            end
            S_A_MARK:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = best_reg[ADDR_W+1:2];
                mem_req.wr_data = {1'b1, best_size_reg};
                res_status_next = ST_OK;
                res_off_next    = AREA_W'(best_reg + POS_W'(HEADER_BYTES));
                state_next      = S_DONE;
            end
            S_F_WALK:
            begin
                if (pos_reg < target_reg)
                begin
                    prev_next      = pos_reg;
                    prev_used_next = ent_used;
                    prev_size_next = ent_size;
                    has_prev_next  = 1'b1;
                    if (npos >= (POS_W+1)'(HEAP_BYTES))
                    begin
                        res_status_next = ST_BADFREE;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        pos_next        = npos[POS_W-1:0];
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = npos[ADDR_W+1:2];
                    end
                end
                else if (pos_reg == target_reg && ent_used)
                begin
                    cur_size_next = ent_size;
                    if (npos >= (POS_W+1)'(HEAP_BYTES))
                    begin
                        state_next = S_F_MERGE;
                    end
                    else
                    begin
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = npos[ADDR_W+1:2];
                        state_next      = S_F_NEXT;
                    end
                end
                else
                begin
                    res_status_next = ST_BADFREE;
                    state_next      = S_DONE;
                end
            end
            S_F_NEXT:
            begin
                if (!ent_used)
                begin
                    cur_size_next = cur_size_reg + ent_size;
                end
                state_next = S_F_MERGE;
            end
            S_F_MERGE:
            begin
                mem_req.wr_en = 1'b1;
                if (has_prev_reg && !prev_used_reg)
                begin
                    mem_req.wr_addr = prev_reg[ADDR_W+1:2];
                    mem_req.wr_data = {1'b0, prev_size_reg + cur_size_reg};
                end
                else
                begin
                    mem_req.wr_addr = pos_reg[ADDR_W+1:2];
                    mem_req.wr_data = {1'b0, cur_size_reg};
                end
                res_status_next = ST_OK;
                state_next      = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign granted_offset = granted_reg;

    `BFHA_ASSERT_NXT(a_accept_busy, in_valid && !in_stall, in_stall)
    `BFHA_ASSERT_IMP(a_write_state, mem_req.wr_en,
        state_reg == S_A_END || state_reg == S_A_MARK || state_reg == S_F_MERGE)
    `BFHA_ASSERT_IMP(a_grant_ok, out_valid && granted_offset != '0, status == ST_OK)
    `BFHA_ASSERT_IMP(a_no_rw_mix, mem_req.rd_en, !mem_req.wr_en)
endmodule

// ----- rtl/best_fit_heap_allocator_top.sv -----
// Best-fit heap allocator over a 4096-byte heap with 16-byte block headers.
// Input channel (in_valid/in_stall): opcode 0 = allocate request_bytes,
// opcode 1 = free the data area at area_offset. One item at a time.
// Output channel (out_valid/out_stall): one result per item, status
// (0 ok, 1 no fit, 2 invalid free) and granted_offset (nonzero only on a
// successful allocate).
// Allocate walks the block headers in order (stopping early on an exact
// fit), then decides in S_A_END and, on a grant, marks the block in S_A_MARK.
// Free walks the chain up to the target block, reads the next header when
// there is one and writes the merged header. The walk rate is set by the
// single header memory read port (one header read per cycle).
// Reset: the header at offset 0 reads as one free block spanning the heap
// until first written; no clearing pass is needed.
// Stall: a finished result sits in the output register; the next item is
// accepted while it waits, and that item's result is held back until the
// output register frees up.
module best_fit_heap_allocator_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        opcode,
    input  logic [15:0] request_bytes,
    input  logic [11:0] area_offset,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [11:0] granted_offset
);
    import bfha_pkg::*;

    mem_req_t         mem_req;
    logic [ENT_W-1:0] ram_rdata;
    logic [ENT_W-1:0] hdr_rdata;
    logic             rd_zero_reg;
    logic             init_done_reg;

    // Entry 0 starts as a free full-heap block until its first write.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_zero_reg   <= 1'b0;
            init_done_reg <= 1'b0;
        end
        else
        begin
            if (mem_req.rd_en)
            begin
                rd_zero_reg <= (mem_req.rd_addr == '0);
            end
            if (mem_req.wr_en && mem_req.wr_addr == '0)
            begin
                init_done_reg <= 1'b1;
            end
        end
    end

    assign hdr_rdata = (rd_zero_reg && !init_done_reg) ? RESET_ENTRY : ram_rdata;

    bfha_ram #(
        .WIDTH (ENT_W),
        .DEPTH (DEPTH)
    ) u_hdr_ram (
        .clk   (clk),
        .re    (mem_req.rd_en),
        .raddr (mem_req.rd_addr),
        .rdata (ram_rdata),
        .we    (mem_req.wr_en),
        .waddr (mem_req.wr_addr),
        .wdata (mem_req.wr_data)
    );

    bfha_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .opcode         (opcode),
        .request_bytes  (request_bytes),
        .area_offset    (area_offset),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .granted_offset (granted_offset),
        .mem_req        (mem_req),
        .mem_rdata      (hdr_rdata)
    );
endmodule

// ----- dv/best_fit_heap_allocator_top_tb.sv -----
module best_fit_heap_allocator_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bfha_pkg::*;

    // Result of one allocator request as the block reports it
    typedef struct {
        logic [1:0]  status;
        logic [11:0] granted_offset;
    } heap_result_t;

    // Heap shadow plus the queue of results still owed by the block
    class heap_scoreboard;
        bit          blk_used[HEAP_BYTES];
        int unsigned blk_size[HEAP_BYTES];
        heap_result_t pending[$];
        int          errors;

        function void clear();
            foreach (blk_used[i])
            begin
                blk_used[i] = 1'b0;
                blk_size[i] = 0;
            end
            blk_size[0] = HEAP_BYTES;
            pending.delete();
            errors = 0;
        endfunction

        function heap_result_t predict_alloc(int unsigned req);
            heap_result_t r;
            int unsigned need;
            int unsigned pos;
            int unsigned best;
            int unsigned sz;
            bit found;
            need = ((req + 3) & ~32'd3) + HEADER_BYTES;
            pos = 0;
            best = 0;
            found = 1'b0;
            while (pos < HEAP_BYTES)
            begin
                sz = blk_size[pos];
                if (!blk_used[pos] && sz >= need && (!found || sz < blk_size[best]))
                begin
                    best = pos;
                    found = 1'b1;
                    if (sz == need)
                        break;
                end
                pos += sz;
            end
            r.status = ST_NOFIT;
            r.granted_offset = '0;
            if (found)
            begin
                // split only when two headers' worth would remain
                if (blk_size[best] >= need + 2 * HEADER_BYTES)
                begin
                    blk_size[best + need] = blk_size[best] - need;
                    blk_used[best + need] = 1'b0;
                    blk_size[best] = need;
                end
                blk_used[best] = 1'b1;
                r.status = ST_OK;
                r.granted_offset = 12'(best + HEADER_BYTES);
            end
            return r;
        endfunction

        function heap_result_t predict_free(int unsigned area);
            heap_result_t r;
            int unsigned pos;
            int unsigned prev;
            int unsigned target;
            int unsigned nxt;
            bit has_prev;
            r.status = ST_BADFREE;
            r.granted_offset = '0;
            if (area < HEADER_BYTES)
                return r;
            target = area - HEADER_BYTES;
            pos = 0;
            prev = 0;
            has_prev = 1'b0;
            while (pos < HEAP_BYTES && pos < target)
            begin
                prev = pos;
                has_prev = 1'b1;
                pos += blk_size[pos];
            end
            if (pos != target || pos >= HEAP_BYTES || !blk_used[pos])
                return r;
            blk_used[pos] = 1'b0;
            nxt = pos + blk_size[pos];
            if (nxt < HEAP_BYTES && !blk_used[nxt])
                blk_size[pos] += blk_size[nxt];
            if (has_prev && !blk_used[prev])
                blk_size[prev] += blk_size[pos];
            r.status = ST_OK;
            return r;
        endfunction

        function void note_request(logic op, logic [15:0] req, logic [11:0] area);
            if (op == OP_ALLOC)
                pending.push_back(predict_alloc(req));
            else
                pending.push_back(predict_free(area));
        endfunction

        function void check_result(logic [1:0] st, logic [11:0] off);
            heap_result_t e;
            if (pending.size() == 0)
            begin
                $error("unexpected result: status %0d granted_offset %0d", st, off);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (st !== e.status)
            begin
                $error("status: expected %0d, actual %0d", e.status, st);
                errors++;
            end
            if (off !== e.granted_offset)
            begin
                $error("granted_offset: expected %0d, actual %0d", e.granted_offset, off);
                errors++;
            end
        endfunction

        // a few live offsets let random frees hit real blocks
        function logic [11:0] used_area();
            int unsigned pos;
            int unsigned hits[$];
            pos = 0;
            while (pos < HEAP_BYTES)
            begin
                if (blk_used[pos])
                    hits.push_back(pos + HEADER_BYTES);
                pos += blk_size[pos];
            end
            if (hits.size() == 0)
                return 12'(HEADER_BYTES);
            return 12'(hits[$urandom_range(hits.size() - 1)]);
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        opcode;
    logic [15:0] request_bytes;
    logic [11:0] area_offset;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  status;
    logic [11:0] granted_offset;

    heap_scoreboard sb;
    int  cycle_count;
    bit  quiet;          // no idling on either side while set
    bit  drained;

    localparam int CYCLE_LIMIT = 3000000;

    best_fit_heap_allocator_top uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .opcode         (opcode),
        .request_bytes  (request_bytes),
        .area_offset    (area_offset),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .granted_offset (granted_offset)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    initial
    begin
        sb = new();
        sb.clear();
        rst_n = 1'b0;
        in_valid = 1'b0;
        opcode = OP_ALLOC;
        request_bytes = '0;
        area_offset = '0;
        out_stall = 1'b0;
        quiet = 1'b0;
        drained = 1'b0;
        cycle_count = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Receiver: random stall, check every accepted result
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                sb.check_result(status, granted_offset);
            out_stall <= quiet ? 1'b0 : ($urandom_range(99) < 8);
        end
    end

    // Drive one item; the request is predicted as it is accepted, so
    // predictions follow input order exactly.
    task automatic send_item(logic op, logic [15:0] req, logic [11:0] area);
        while (!quiet && $urandom_range(99) < 8)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode <= op;
        request_bytes <= req;
        area_offset <= area;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_request(op, req, area);
    endtask

    task automatic send_alloc(logic [15:0] req);
        send_item(OP_ALLOC, req, 12'($urandom));
    endtask

    task automatic send_free(logic [11:0] area);
        send_item(OP_FREE, 16'($urandom), area);
    endtask

    // Mostly small sizes so the heap fills and fragments; a few large ones
    function automatic logic [15:0] pick_size();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 70)
            return 16'($urandom_range(64));
        if (r < 90)
            return 16'($urandom_range(600));
        if (r < 95)
            return 16'($urandom_range(4096));
        return 16'($urandom);
    endfunction

    initial
    begin
        int unsigned r;
        int unsigned wait_cycles;
        @(posedge rst_n);
        @(posedge clk);

        // Directed: oversized, full heap, exact fit, zero-byte, invalid frees
        send_alloc(16'hFFFF);                       // far above the heap
        send_alloc(16'(HEAP_BYTES));                // header pushes it over
        send_alloc(16'(HEAP_BYTES - HEADER_BYTES)); // exact fit of whole heap
        send_alloc(16'd0);                          // heap full
        send_free(12'd0);                           // below header size
        send_free(12'(HEADER_BYTES));               // frees the whole heap
        send_free(12'(HEADER_BYTES));               // now a double free
        send_alloc(16'd0);                          // header-only block
        send_alloc(16'd1);                          // rounds up to 4
        send_alloc(16'd5);
        send_alloc(16'd100);
        send_free(12'd4095);                        // no block starts there
        send_free(12'd20);                          // mid-block
        send_free(12'd48);                          // inside the second block, not at its start
        send_free(12'd16);                          // first block, next block still used
        send_alloc(16'd12);                         // hole too small; taken from the tail block
        send_alloc(16'd3000);                       // big tail block
        send_free(sb.used_area());
        send_free(sb.used_area());
        send_alloc(16'd2);
        send_alloc(16'hAAAA);
        send_alloc(16'h5555);
        send_free(12'hAAA);
        send_free(12'h555);

        // Random: well-formed alloc/free churn, some junk frees
        for (int i = 0; i < 1900; i++)
        begin
            quiet = (i >= 600 && i < 900);
            r = $urandom_range(99);
            if (r < 55)
                send_alloc(pick_size());
            else if (r < 92)
                send_free(sb.used_area());
            else if (r < 96)
                send_free(12'($urandom));
            else
                send_free(12'(sb.used_area() + 4 * $urandom_range(1, 3)));
        end
        in_valid <= 1'b0;

        wait_cycles = 0;
        while (sb.pending.size() != 0 && wait_cycles < 100000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (300) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
